@@ rtl/anlb_pkg.sv @@
`timescale 1ns / 1ps

package anlb_pkg;

    // Field widths
    localparam int SAMPLE_W = 10;
    localparam int FILT_W   = 18;
    localparam int ALPHA_W  = 9;
    localparam int LEVEL_W  = 8;
    localparam int COUNT_W  = 8;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;

    // Full-scale alpha: previous filtered value fully weighted
    localparam logic [ALPHA_W-1:0] ALPHA_FULL = 9'd256;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] DARK_THRESHOLD_RST  = 10'd500;
    localparam logic [SAMPLE_W-1:0] DARK_HYSTERESIS_RST = 10'd200;
    localparam logic [ALPHA_W-1:0]  FILTER_ALPHA_RST    = 9'd255;
    localparam logic [LEVEL_W-1:0]  BREATH_MIN_RST      = 8'd1;
    localparam logic [LEVEL_W-1:0]  BREATH_MAX_RST      = 8'd60;
    localparam logic [LEVEL_W-1:0]  BREATH_STEP_RST     = 8'd1;
    localparam logic [COUNT_W-1:0]  SAMPLE_PERIOD_RST   = 8'd10;
    localparam logic [COUNT_W-1:0]  BREATH_PERIOD_RST   = 8'd20;
    localparam logic [LEVEL_W-1:0]  LEVEL_RST           = 8'd1;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DARK_THRESHOLD  = 3'd0,
        REG_DARK_HYSTERESIS = 3'd1,
        REG_FILTER_ALPHA    = 3'd2,
        REG_BREATH_MIN      = 3'd3,
        REG_BREATH_MAX      = 3'd4,
        REG_BREATH_STEP     = 3'd5,
        REG_SAMPLE_PERIOD   = 3'd6,
        REG_BREATH_PERIOD   = 3'd7
    } cfg_reg_t;

    // Result of one filter update and threshold decision
    typedef struct packed {
        logic [FILT_W-1:0] filtered;
        logic              night;
    } filt_upd_t;

endpackage

@@ rtl/ambient_night_light_breather.sv @@
`timescale 1ns / 1ps

// Night-light controller: every input transaction is one loop tick carrying a
// 10-bit ambient reading. On sample ticks the reading feeds a first-order
// low-pass filter and a hysteresis threshold that turns night mode on or off;
// PWM enable follows night mode and the duty latches the breathing level.
// On breath ticks with night mode on, the level ramps between breath_min and
// breath_max. Each tick yields exactly one output transaction. The filter
// multiply-add, threshold compare and level step all sit between the state
// registers and the output register, so a new tick is taken every cycle while
// the output register is empty or being drained. Results are registered and
// appear in the cycle after the tick is accepted. Configuration writes
// take effect on the next tick and should be made while no tick is in flight.
module ambient_night_light_breather
    import anlb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [9:0] light_sample, rest zero

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] night_on, [1] pwm_on, [9:2] pwm_duty, [17:10] breath_level,
    // [27:18] filtered_light, rest zero
    output logic [M_TDATA_W-1:0]  m_axis_tdata,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [SAMPLE_W-1:0] dark_threshold_reg;
    logic [SAMPLE_W-1:0] dark_hysteresis_reg;
    logic [ALPHA_W-1:0]  filter_alpha_reg;
    logic [LEVEL_W-1:0]  breath_min_reg;
    logic [LEVEL_W-1:0]  breath_max_reg;
    logic [LEVEL_W-1:0]  breath_step_reg;
    logic [COUNT_W-1:0]  sample_period_reg;
    logic [COUNT_W-1:0]  breath_period_reg;

    // Loop state
    logic [FILT_W-1:0]   filt_reg,         filt_next;
    logic                night_reg,        night_next;
    logic [LEVEL_W-1:0]  level_reg,        level_next;
    logic                rising_reg,       rising_next;
    logic [COUNT_W-1:0]  sample_cnt_reg,   sample_cnt_next;
    logic [COUNT_W-1:0]  breath_cnt_reg,   breath_cnt_next;
    logic [LEVEL_W-1:0]  duty_reg,         duty_next;
    logic                pwm_en_reg,       pwm_en_next;

    // Output register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;

    logic                 in_xact;
    logic                 sample_tick;
    logic                 breath_tick;
    filt_upd_t            upd;
    logic [LEVEL_W:0]     level_up;
    logic [LEVEL_W:0]     min_plus_step;

    assign in_xact       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_threshold_reg  <= DARK_THRESHOLD_RST;
            dark_hysteresis_reg <= DARK_HYSTERESIS_RST;
            filter_alpha_reg    <= FILTER_ALPHA_RST;
            breath_min_reg      <= BREATH_MIN_RST;
            breath_max_reg      <= BREATH_MAX_RST;
            breath_step_reg     <= BREATH_STEP_RST;
            sample_period_reg   <= SAMPLE_PERIOD_RST;
            breath_period_reg   <= BREATH_PERIOD_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DARK_THRESHOLD:  dark_threshold_reg  <= cfg_data;
                REG_DARK_HYSTERESIS: dark_hysteresis_reg <= cfg_data;
                REG_FILTER_ALPHA:    filter_alpha_reg    <= cfg_data[ALPHA_W-1:0];
                REG_BREATH_MIN:      breath_min_reg      <= cfg_data[LEVEL_W-1:0];
                REG_BREATH_MAX:      breath_max_reg      <= cfg_data[LEVEL_W-1:0];
                REG_BREATH_STEP:     breath_step_reg     <= cfg_data[LEVEL_W-1:0];
                REG_SAMPLE_PERIOD:   sample_period_reg   <= cfg_data[COUNT_W-1:0];
                REG_BREATH_PERIOD:   breath_period_reg   <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Filter and threshold
    anlb_filter u_filter (
        .light_sample    (s_axis_tdata[SAMPLE_W-1:0]),
        .filtered_cur    (filt_reg),
        .night_cur       (night_reg),
        .filter_alpha    (filter_alpha_reg),
        .dark_threshold  (dark_threshold_reg),
        .dark_hysteresis (dark_hysteresis_reg),
        .upd             (upd)
    );

    assign sample_tick   = (sample_cnt_reg == '0);
    assign breath_tick   = (breath_cnt_reg == '0);
    assign level_up      = {1'b0, level_reg} + {1'b0, breath_step_reg};
    assign min_plus_step = {1'b0, breath_min_reg} + {1'b0, breath_step_reg};

    // Next state for one tick
    always_comb
    begin
        filt_next   = filt_reg;
        night_next  = night_reg;
        pwm_en_next = pwm_en_reg;
        duty_next   = duty_reg;
        level_next  = level_reg;
        rising_next = rising_reg;

        if (sample_tick)
        begin
            filt_next   = upd.filtered;
            night_next  = upd.night;
            pwm_en_next = upd.night;
            if (upd.night)
            begin
                duty_next = level_reg;
            end
        end

        if (night_next && breath_tick)
        begin
            if (rising_reg)
            begin
                if (level_up <= {1'b0, breath_max_reg})
                    level_next = level_up[LEVEL_W-1:0];
                else
                    rising_next = 1'b0;
            end
            else
            begin
                if ({1'b0, level_reg} >= min_plus_step)
                    level_next = level_reg - breath_step_reg;
                else
                    rising_next = 1'b1;
            end
        end
    end

    // Tick counters; a zero period counts as one
    always_comb
    begin
        logic [COUNT_W:0] s_inc;
        logic [COUNT_W:0] b_inc;
        s_inc = {1'b0, sample_cnt_reg} + 1'b1;
        b_inc = {1'b0, breath_cnt_reg} + 1'b1;
        if (sample_period_reg == '0 || s_inc >= {1'b0, sample_period_reg})
            sample_cnt_next = '0;
        else
            sample_cnt_next = s_inc[COUNT_W-1:0];
        if (breath_period_reg == '0 || b_inc >= {1'b0, breath_period_reg})
            breath_cnt_next = '0;
        else
            breath_cnt_next = b_inc[COUNT_W-1:0];
    end

    assign out_data_next = {4'd0, filt_next[FILT_W-1:8], level_next, duty_next,
                            pwm_en_next, night_next};

    // State update on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg       <= '0;
            night_reg      <= 1'b0;
            level_reg      <= LEVEL_RST;
            rising_reg     <= 1'b1;
            sample_cnt_reg <= '0;
            breath_cnt_reg <= '0;
            duty_reg       <= '0;
            pwm_en_reg     <= 1'b0;
        end
        else if (in_xact)
        begin
            filt_reg       <= filt_next;
            night_reg      <= night_next;
            level_reg      <= level_next;
            rising_reg     <= rising_next;
            sample_cnt_reg <= sample_cnt_next;
            breath_cnt_reg <= breath_cnt_next;
            duty_reg       <= duty_next;
            pwm_en_reg     <= pwm_en_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xact)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xact)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Checks
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_xact |=> m_axis_tvalid)
        else $error("accepted tick produced no result");

    a_pwm_tracks_night: assert property (@(posedge clk) disable iff (!rst_n)
        pwm_en_reg == night_reg)
        else $error("pwm enable diverged from night mode");

    a_level_needs_night: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(level_reg) |-> night_reg)
        else $error("breath level moved with night mode off");

    a_filter_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(filt_reg) |-> $past(in_xact && sample_tick))
        else $error("filter changed outside a sample tick");

endmodule

@@ rtl/anlb_filter.sv @@
`timescale 1ns / 1ps

module anlb_filter
    import anlb_pkg::*;
(
    input  logic [SAMPLE_W-1:0] light_sample,
    input  logic [FILT_W-1:0]   filtered_cur,
    input  logic                night_cur,
    input  logic [ALPHA_W-1:0]  filter_alpha,
    input  logic [SAMPLE_W-1:0] dark_threshold,
    input  logic [SAMPLE_W-1:0] dark_hysteresis,
    output filt_upd_t           upd
);

    logic [ALPHA_W-1:0]          alpha_sat;
    logic [ALPHA_W-1:0]          alpha_inv;
    logic [ALPHA_W+SAMPLE_W-1:0] prod_x;
    logic [ALPHA_W+FILT_W-1:0]   prod_y;
    logic [ALPHA_W+FILT_W:0]     sum;
    logic [SAMPLE_W-1:0]         lower;
    logic [SAMPLE_W-1:0]         limit;
    logic [FILT_W-1:0]           filt_new;

    // Alpha above full scale holds the filter
    assign alpha_sat = (filter_alpha > ALPHA_FULL) ? ALPHA_FULL : filter_alpha;
    assign alpha_inv = ALPHA_FULL - alpha_sat;

    // Weighted sum: (256-a)*x*256 + a*y, then drop 8 fraction bits
    assign prod_x = alpha_inv * light_sample;
    assign prod_y = alpha_sat * filtered_cur;
    assign sum    = {1'b0, prod_x, 8'd0} + {1'b0, prod_y};
    assign filt_new = sum[FILT_W+7:8];

    // Hysteresis: lower threshold while night is on, saturated at zero
    assign lower = (dark_threshold > dark_hysteresis) ? (dark_threshold - dark_hysteresis)
                                                      : '0;
    assign limit = night_cur ? lower : dark_threshold;

    assign upd.filtered = filt_new;
    assign upd.night    = (filt_new[FILT_W-1:8] > limit);

endmodule
